### design/awm_pkg.sv
// Shared types, sizes and command codes of the sliding-window anagram matcher.
package awm_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int ALPHABET    = 26;
  localparam int BINS        = ALPHABET + 1;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;
  localparam int BIN_W    = $clog2(BINS);
  localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
  localparam int POS_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int DIFF_W   = $clog2(BINS + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PEND_W     = $clog2(FIFO_DEPTH + 3);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } awm_cmd_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } awm_kind_e;

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [LEN_W-1:0] cnt_t;

  typedef struct packed {
    logic      vld;
    awm_kind_e kind;
    bin_t      bin;
    logic      upd;
    logic      rem;
    logic      fill_ok;
    logic      ovf;
    logic      last;
  } awm_op_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic end_of_text;
    logic pattern_overflow;
  } awm_out_t;

  typedef struct packed {
    logic     vld;
    awm_out_t data;
  } awm_res_t;

  typedef struct packed {
    cnt_t pat;
    cnt_t rem;
  } awm_pr_t;

  function automatic bin_t bin_of(logic [LETTER_W-1:0] letter);
    return (int'(letter) < ALPHABET) ? BIN_W'(letter) : BIN_W'(ALPHABET);
  endfunction

endpackage

### design/anagram_window_matcher.sv
// Top level of the sliding-window anagram matcher: command decode, letter ring and result buffer.
// The block takes one command per cycle while in_ready_o is high and gives one result for every
// text letter, through the op_b_q and op_q registers and a four-entry output buffer; ready falls
// only when that buffer together with the results still in flight would exceed four entries.
// The pace is set by the read-modify-write loop on the histogram memories, which forwards the
// previous cycle's write so that every letter updates both histogram bins it touches.
// There is no clearing pass after reset: valid bits clear the histograms at once, and the
// letter ring is only read at positions written earlier in the same text.
module anagram_window_matcher import awm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [LETTER_W-1:0] letter_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                window_match_o,
  output logic                found_o,
  output logic                end_of_text_o,
  output logic                pattern_overflow_o
);

  bin_t ring_mem [MAX_PATTERN];
  bin_t ring_rd_q;

  cnt_t             pat_len_q, pat_len_d, fill_q, fill_d, fill_inc, pos_inc;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             ovf_q, ovf_d;
  logic             accept, ring_we;
  bin_t             bin_in;
  awm_op_t          op_d, op_b_q;
  awm_res_t         res;

  awm_out_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [PEND_W-1:0]     pend;
  logic                  push, pop;

  assign accept   = in_valid_i && in_ready_o;
  assign bin_in   = bin_of(letter_i);
  assign fill_inc = fill_q + cnt_t'(1);
  assign pos_inc  = cnt_t'(pos_q) + cnt_t'(1);

  always_comb begin
    pat_len_d = pat_len_q;
    ovf_d     = ovf_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    ring_we   = 1'b0;
    op_d      = '0;
    if (accept) begin
      unique case (awm_cmd_e'(cmd_i))
        CMD_CLEAR: begin
          pat_len_d = '0;
          ovf_d     = 1'b0;
          fill_d    = '0;
          pos_d     = '0;
          op_d.vld  = 1'b1;
          op_d.kind = OP_CLEAR;
        end
        CMD_PATTERN: begin
          if (fill_q == '0) begin
            if (pat_len_q == cnt_t'(MAX_PATTERN)) begin
              ovf_d = 1'b1;
            end else begin
              pat_len_d = pat_len_q + cnt_t'(1);
              op_d.vld  = 1'b1;
              op_d.kind = OP_PATTERN;
              op_d.bin  = bin_in;
            end
          end
        end
        CMD_TEXT: begin
          op_d.vld     = 1'b1;
          op_d.kind    = OP_TEXT;
          op_d.bin     = bin_in;
          op_d.last    = last_i;
          op_d.ovf     = ovf_q;
          op_d.upd     = pat_len_q != '0;
          op_d.rem     = op_d.upd && fill_q >= pat_len_q;
          op_d.fill_ok = 1'b1;
          if (op_d.upd) begin
            ring_we      = 1'b1;
            op_d.fill_ok = op_d.rem || fill_inc >= pat_len_q;
            if (!op_d.rem) begin
              fill_d = fill_inc;
            end
            pos_d = (pos_inc == pat_len_q) ? '0 : POS_W'(pos_inc);
          end
          if (last_i) begin
            fill_d = '0;
            pos_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= bin_in;
    end
    ring_rd_q <= ring_mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      ovf_q     <= 1'b0;
      fill_q    <= '0;
      pos_q     <= '0;
      op_b_q    <= '0;
    end else begin
      pat_len_q <= pat_len_d;
      ovf_q     <= ovf_d;
      fill_q    <= fill_d;
      pos_q     <= pos_d;
      op_b_q    <= op_d;
    end
  end

  awm_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_b_q),
    .ring_bin_i (ring_rd_q),
    .res_o      (res)
  );

  // Results still in the pipeline hold a reserved buffer entry.
  assign pend = PEND_W'(cnt_q) + PEND_W'(op_b_q.vld && op_b_q.kind == OP_TEXT) +
                PEND_W'(res.vld);
  assign in_ready_o = pend < PEND_W'(FIFO_DEPTH);

  assign push  = res.vld;
  assign pop   = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= res.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o        = cnt_q != '0;
  assign window_match_o     = fifo_mem[rd_ptr_q].window_match;
  assign found_o            = fifo_mem[rd_ptr_q].found;
  assign end_of_text_o      = fifo_mem[rd_ptr_q].end_of_text;
  assign pattern_overflow_o = fifo_mem[rd_ptr_q].pattern_overflow;

endmodule

### design/awm_hist.sv
// Histogram memories with read-modify-write, forwarding and the differing-bin count.
module awm_hist import awm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  awm_op_t  op_i,
  input  bin_t     ring_bin_i,
  output awm_res_t res_o
);

  cnt_t    add_mem [BINS];
  awm_pr_t pr_mem  [BINS];

  cnt_t    add_a_rd_q, add_r_rd_q;
  awm_pr_t pr_a_rd_q, pr_r_rd_q;

  awm_op_t op_q;
  bin_t    bin_r_q;

  logic [BINS-1:0] avld_q, avld_d, pvld_q, pvld_d, rvld_q, rvld_d;

  logic    fa_vld_q, fa_vld_d;
  bin_t    fa_bin_q, fa_bin_d;
  cnt_t    fa_val_q, fa_val_d;
  logic    fp_vld_q, fp_vld_d;
  bin_t    fp_bin_q, fp_bin_d;
  awm_pr_t fp_word_q, fp_word_d;

  logic [DIFF_W-1:0] diff_q, diff_d, pat_bins_q, pat_bins_d, diff_upd;
  logic              found_q, found_d;

  cnt_t    add_a, add_r, pat_a, pat_r, rem_a, rem_r, win_a, win_r;
  cnt_t    win_a_inc, win_r_dec, pat_a_inc;
  logic    add_we, pr_we;
  bin_t    add_wa, pr_wa;
  cnt_t    add_wd;
  awm_pr_t pr_wd;
  logic    same, a_chg, r_chg, old_a, new_a, old_r, new_r;
  logic    up_a, up_r, dn_a, dn_r, match;

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      add_mem[add_wa] <= add_wd;
    end
    if (pr_we) begin
      pr_mem[pr_wa] <= pr_wd;
    end
    add_a_rd_q <= add_mem[op_i.bin];
    add_r_rd_q <= add_mem[ring_bin_i];
    pr_a_rd_q  <= pr_mem[op_i.bin];
    pr_r_rd_q  <= pr_mem[ring_bin_i];
  end

  // A write from the previous cycle is missed by the read issued in that cycle.
  always_comb begin
    if (fa_vld_q && fa_bin_q == op_q.bin) begin
      add_a = fa_val_q;
    end else begin
      add_a = avld_q[op_q.bin] ? add_a_rd_q : '0;
    end
    if (fa_vld_q && fa_bin_q == bin_r_q) begin
      add_r = fa_val_q;
    end else begin
      add_r = avld_q[bin_r_q] ? add_r_rd_q : '0;
    end
    if (fp_vld_q && fp_bin_q == op_q.bin) begin
      pat_a = fp_word_q.pat;
      rem_a = fp_word_q.rem;
    end else begin
      pat_a = pvld_q[op_q.bin] ? pr_a_rd_q.pat : '0;
      rem_a = rvld_q[op_q.bin] ? pr_a_rd_q.rem : '0;
    end
    if (fp_vld_q && fp_bin_q == bin_r_q) begin
      pat_r = fp_word_q.pat;
      rem_r = fp_word_q.rem;
    end else begin
      pat_r = pvld_q[bin_r_q] ? pr_r_rd_q.pat : '0;
      rem_r = rvld_q[bin_r_q] ? pr_r_rd_q.rem : '0;
    end
    win_a     = add_a - rem_a;
    win_r     = add_r - rem_r;
    win_a_inc = win_a + cnt_t'(1);
    win_r_dec = win_r - cnt_t'(1);
    pat_a_inc = pat_a + cnt_t'(1);
  end

  always_comb begin
    avld_d     = avld_q;
    pvld_d     = pvld_q;
    rvld_d     = rvld_q;
    pat_bins_d = pat_bins_q;
    add_we     = 1'b0;
    add_wa     = op_q.bin;
    add_wd     = win_a_inc + rem_a;
    pr_we      = 1'b0;
    pr_wa      = op_q.bin;
    pr_wd      = '{pat: pat_a_inc, rem: rem_a};
    same       = 1'b0;
    a_chg      = 1'b0;
    r_chg      = 1'b0;
    old_a      = 1'b0;
    new_a      = 1'b0;
    old_r      = 1'b0;
    new_r      = 1'b0;

    if (op_q.vld) begin
      unique case (op_q.kind)
        OP_PATTERN: begin
          a_chg  = 1'b1;
          old_a  = win_a != pat_a;
          new_a  = win_a != pat_a_inc;
          pr_we  = 1'b1;
          pvld_d[op_q.bin] = 1'b1;
          if (pat_a == '0) begin
            pat_bins_d = pat_bins_q + DIFF_W'(1);
          end
        end
        OP_TEXT: begin
          if (op_q.upd) begin
            same   = op_q.rem && (bin_r_q == op_q.bin);
            a_chg  = !same;
            old_a  = win_a != pat_a;
            new_a  = win_a_inc != pat_a;
            r_chg  = op_q.rem && !same;
            old_r  = win_r != pat_r;
            new_r  = win_r_dec != pat_r;
            add_we = 1'b1;
            add_wd = add_a + cnt_t'(1);
            avld_d[op_q.bin] = 1'b1;
            if (op_q.rem) begin
              pr_we = 1'b1;
              pr_wa = bin_r_q;
              pr_wd = '{pat: pat_r, rem: rem_r + cnt_t'(1)};
              rvld_d[bin_r_q] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    up_a     = a_chg && !old_a && new_a;
    dn_a     = a_chg && old_a && !new_a;
    up_r     = r_chg && !old_r && new_r;
    dn_r     = r_chg && old_r && !new_r;
    diff_upd = diff_q + DIFF_W'(up_a) + DIFF_W'(up_r) - DIFF_W'(dn_a) - DIFF_W'(dn_r);
    match    = op_q.vld && op_q.kind == OP_TEXT && !op_q.ovf && op_q.fill_ok &&
               diff_upd == '0;

    diff_d    = diff_upd;
    found_d   = found_q | match;
    fa_vld_d  = add_we;
    fa_bin_d  = add_wa;
    fa_val_d  = add_wd;
    fp_vld_d  = pr_we;
    fp_bin_d  = pr_wa;
    fp_word_d = pr_wd;

    // The end of a text empties the window but keeps the pattern.
    if (op_q.vld && op_q.kind == OP_TEXT && op_q.last) begin
      avld_d   = '0;
      rvld_d   = '0;
      diff_d   = pat_bins_q;
      found_d  = 1'b0;
      fa_vld_d = 1'b0;
      fp_vld_d = 1'b0;
    end
    if (op_q.vld && op_q.kind == OP_CLEAR) begin
      avld_d     = '0;
      pvld_d     = '0;
      rvld_d     = '0;
      pat_bins_d = '0;
      diff_d     = '0;
      found_d    = 1'b0;
      fa_vld_d   = 1'b0;
      fp_vld_d   = 1'b0;
    end
  end

  assign res_o.vld                   = op_q.vld && op_q.kind == OP_TEXT;
  assign res_o.data.window_match     = match;
  assign res_o.data.found            = found_q | match;
  assign res_o.data.end_of_text      = op_q.last;
  assign res_o.data.pattern_overflow = op_q.ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= '0;
      avld_q     <= '0;
      pvld_q     <= '0;
      rvld_q     <= '0;
      fa_vld_q   <= 1'b0;
      fp_vld_q   <= 1'b0;
      diff_q     <= '0;
      pat_bins_q <= '0;
      found_q    <= 1'b0;
    end else begin
      op_q       <= op_i;
      avld_q     <= avld_d;
      pvld_q     <= pvld_d;
      rvld_q     <= rvld_d;
      fa_vld_q   <= fa_vld_d;
      fp_vld_q   <= fp_vld_d;
      diff_q     <= diff_d;
      pat_bins_q <= pat_bins_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_r_q   <= ring_bin_i;
    fa_bin_q  <= fa_bin_d;
    fa_val_q  <= fa_val_d;
    fp_bin_q  <= fp_bin_d;
    fp_word_q <= fp_word_d;
  end

endmodule

### sim/anagram_window_matcher_tb.sv
// Self-checking testbench of the sliding-window anagram matcher with its own verdict predictor.
module anagram_window_matcher_tb;
  import awm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_LEN = 60;
  localparam int PHASE_TEXT_LETTERS = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum int {
    PH_DIRECT,
    PH_FREE,
    PH_PRESSURE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } load_phase_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LETTER_W-1:0] letter;
    logic                last_bit;
  } command_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic end_of_text;
    logic pattern_overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [LETTER_W-1:0] letter = '0;
  logic last_bit = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic window_match;
  logic found;
  logic end_of_text;
  logic pattern_overflow;

  load_phase_e phase = PH_DIRECT;
  int hold_cnt = 0;
  int unsigned cycle_cnt = 0;
  int mismatch_cnt = 0;
  int text_letters_queued = 0;

  command_t command_q[$];
  verdict_t verdict_q[$];

  logic [8:0] pat_hist[BINS];
  logic [8:0] win_hist[BINS];
  logic [LETTER_W-1:0] ring_mem[MAX_PATTERN];
  int unsigned pat_len;
  int unsigned text_fill;
  int unsigned ring_pos;
  int diff_bins;
  bit found_seen;
  bit overflow_seen;

  anagram_window_matcher u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .cmd_i             (cmd),
    .letter_i          (letter),
    .last_i            (last_bit),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .window_match_o    (window_match),
    .found_o           (found),
    .end_of_text_o     (end_of_text),
    .pattern_overflow_o(pattern_overflow)
  );

  always #5 clk = ~clk;

  function automatic int unsigned bin_index(logic [LETTER_W-1:0] l);
    return (int'(l) < ALPHABET) ? int'(l) : ALPHABET;
  endfunction

  task automatic tally(input bit in_pattern, input int unsigned b, input bit up);
    bit was_diff;
    bit now_diff;
    was_diff = pat_hist[b] != win_hist[b];
    if (in_pattern) begin
      pat_hist[b] = pat_hist[b] + 9'd1;
    end else if (up) begin
      win_hist[b] = win_hist[b] + 9'd1;
    end else if (win_hist[b] != 9'd0) begin
      win_hist[b] = win_hist[b] - 9'd1;
    end
    now_diff = pat_hist[b] != win_hist[b];
    if (was_diff && !now_diff) begin
      diff_bins--;
    end else if (!was_diff && now_diff) begin
      diff_bins++;
    end
  endtask

  task automatic restart_window();
    text_fill = 0;
    ring_pos = 0;
    found_seen = 1'b0;
    diff_bins = 0;
    for (int b = 0; b < BINS; b++) begin
      win_hist[b] = '0;
      if (pat_hist[b] != 9'd0) begin
        diff_bins++;
      end
    end
  endtask

  task automatic clear_matcher();
    for (int b = 0; b < BINS; b++) begin
      pat_hist[b] = '0;
    end
    pat_len = 0;
    overflow_seen = 1'b0;
    restart_window();
  endtask

  task automatic predict_verdict(input command_t c);
    int unsigned b;
    int unsigned pos;
    verdict_t v;
    b = bin_index(c.letter);
    if (c.cmd == CMD_CLEAR) begin
      clear_matcher();
    end else if (c.cmd == CMD_PATTERN) begin
      if (text_fill == 0) begin
        if (pat_len >= MAX_PATTERN) begin
          overflow_seen = 1'b1;
        end else begin
          tally(1'b1, b, 1'b1);
          pat_len++;
        end
      end
    end else if (c.cmd == CMD_TEXT) begin
      if (pat_len != 0) begin
        pos = ring_pos % pat_len;
        if (text_fill >= pat_len) begin
          tally(1'b0, bin_index(ring_mem[pos]), 1'b0);
        end else begin
          text_fill++;
        end
        ring_mem[pos] = c.letter;
        tally(1'b0, b, 1'b1);
        ring_pos = (pos + 1) % pat_len;
      end
      v.window_match = !overflow_seen && text_fill >= pat_len && diff_bins == 0;
      if (v.window_match) begin
        found_seen = 1'b1;
      end
      v.found = found_seen;
      v.end_of_text = c.last_bit;
      v.pattern_overflow = overflow_seen;
      verdict_q.push_back(v);
      if (c.last_bit) begin
        restart_window();
      end
    end
  endtask

  function automatic bit sender_idles();
    case (phase)
      PH_SEND_IDLE: return $urandom_range(99) < 85;
      PH_BOTH:      return $urandom_range(99) < 23;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_ready();
    case (phase)
      PH_RECV_STALL: return $urandom_range(99) >= 85;
      PH_BOTH:       return $urandom_range(99) >= 23;
      PH_PRESSURE:   return hold_cnt >= HOLD_LEN;
      default:       return 1'b1;
    endcase
  endfunction

  always @(posedge clk or negedge rst_ni) begin : driver
    command_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cmd <= '0;
      letter <= '0;
      last_bit <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_verdict('{cmd: cmd, letter: letter, last_bit: last_bit});
      end
      if (!in_valid || in_ready) begin
        if (command_q.size() != 0 && !sender_idles()) begin
          nxt = command_q.pop_front();
          in_valid <= 1'b1;
          cmd <= nxt.cmd;
          letter <= nxt.letter;
          last_bit <= nxt.last_bit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_ni) begin : monitor
    verdict_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transfer");
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (window_match !== want.window_match) begin
            $error("window_match: expected %0b, actual %0b", want.window_match, window_match);
            mismatch_cnt++;
          end
          if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            mismatch_cnt++;
          end
          if (end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %0b, actual %0b", want.end_of_text, end_of_text);
            mismatch_cnt++;
          end
          if (pattern_overflow !== want.pattern_overflow) begin
            $error("pattern_overflow: expected %0b, actual %0b", want.pattern_overflow,
                   pattern_overflow);
            mismatch_cnt++;
          end
        end
      end
      out_ready <= receiver_ready();
    end
  end

  always @(posedge clk or negedge rst_ni) begin : hold_off
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (phase == PH_PRESSURE && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("anagram_window_matcher_tb: FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l,
                           input logic lst);
    command_q.push_back('{cmd: c, letter: l, last_bit: lst});
    if (c == CMD_TEXT) begin
      text_letters_queued++;
    end
  endtask

  // A pattern of the given length, a text that holds a permutation of it, then one more
  // pattern letter that overflows and a short text that sees the overflow.
  task automatic add_long_session(input int plen);
    logic [LETTER_W-1:0] pat[$];
    logic [LETTER_W-1:0] tmp;
    int j;
    int tlen;
    push_item(CMD_CLEAR, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
    for (int i = 0; i < plen; i++) begin
      pat.push_back(LETTER_W'($urandom_range(31)));
      push_item(CMD_PATTERN, pat[i], 1'($urandom_range(1)));
    end
    for (int i = pat.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pat[i];
      pat[i] = pat[j];
      pat[j] = tmp;
    end
    for (int i = 0; i < 4; i++) begin
      pat.push_back(LETTER_W'($urandom_range(31)));
    end
    tlen = pat.size();
    for (int i = 0; i < tlen; i++) begin
      push_item(CMD_TEXT, pat[i], i == tlen - 1);
    end
    push_item(CMD_PATTERN, LETTER_W'($urandom_range(31)), 1'b0);
    for (int i = 0; i < 3; i++) begin
      push_item(CMD_TEXT, pat[i], i == 2);
    end
  endtask

  task automatic add_session();
    logic [LETTER_W-1:0] pool[3];
    int pool_n;
    int plen;
    int ntext;
    int tlen;
    logic [LETTER_W-1:0] l;
    pool_n = $urandom_range(1, 3);
    for (int i = 0; i < 3; i++) begin
      pool[i] = LETTER_W'($urandom_range(31));
    end
    if ($urandom_range(2) == 0) begin
      push_item(CMD_CLEAR, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
    end
    plen = ($urandom_range(49) == 0) ? $urandom_range(MAX_PATTERN, MAX_PATTERN + 2)
                                     : $urandom_range(0, 5);
    for (int i = 0; i < plen; i++) begin
      push_item(CMD_PATTERN, pool[$urandom_range(pool_n - 1)], 1'($urandom_range(1)));
    end
    ntext = $urandom_range(1, 3);
    for (int t = 0; t < ntext; t++) begin
      tlen = $urandom_range(1, 12);
      for (int k = 0; k < tlen; k++) begin
        l = ($urandom_range(9) == 0) ? LETTER_W'($urandom_range(31))
                                     : pool[$urandom_range(pool_n - 1)];
        push_item(CMD_TEXT, l, (k == tlen - 1) && ($urandom_range(7) != 0));
        if ($urandom_range(14) == 0) begin
          push_item($urandom_range(1) ? CMD_UNUSED : CMD_PATTERN,
                    LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic drain();
    while (command_q.size() != 0 || in_valid || verdict_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    load_phase_e plan[5];
    plan = '{PH_FREE, PH_PRESSURE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH};
    clear_matcher();
    for (int i = 0; i < MAX_PATTERN; i++) begin
      ring_mem[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_ni = 1'b1;

    // Empty pattern, extra-symbol letters, ignored commands and pattern extension.
    push_item(CMD_CLEAR, 5'd0, 1'b0);
    push_item(CMD_TEXT, 5'd0, 1'b0);
    push_item(CMD_TEXT, 5'd31, 1'b1);
    push_item(CMD_PATTERN, 5'd0, 1'b0);
    push_item(CMD_PATTERN, 5'd31, 1'b1);
    push_item(CMD_PATTERN, 5'd26, 1'b0);
    push_item(CMD_TEXT, 5'd27, 1'b0);
    push_item(CMD_TEXT, 5'd0, 1'b0);
    push_item(CMD_PATTERN, 5'd5, 1'b0);
    push_item(CMD_TEXT, 5'd30, 1'b0);
    push_item(CMD_TEXT, 5'd1, 1'b0);
    push_item(CMD_UNUSED, 5'd31, 1'b1);
    push_item(CMD_TEXT, 5'd0, 1'b1);
    push_item(CMD_PATTERN, 5'd25, 1'b0);
    push_item(CMD_TEXT, 5'd25, 1'b0);
    push_item(CMD_TEXT, 5'd26, 1'b0);
    push_item(CMD_TEXT, 5'd0, 1'b0);
    push_item(CMD_TEXT, 5'd28, 1'b1);
    push_item(CMD_CLEAR, 5'd31, 1'b1);
    push_item(CMD_PATTERN, 5'd7, 1'b0);
    push_item(CMD_TEXT, 5'd7, 1'b1);
    push_item(CMD_TEXT, 5'd8, 1'b0);
    push_item(CMD_CLEAR, 5'd31, 1'b1);
    drain();

    foreach (plan[p]) begin
      @(negedge clk);
      phase = plan[p];
      text_letters_queued = 0;
      if (plan[p] == PH_FREE) begin
        add_long_session(MAX_PATTERN);
        text_letters_queued = 0;
      end
      while (text_letters_queued < PHASE_TEXT_LETTERS) begin
        add_session();
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("anagram_window_matcher_tb: PASS");
    end else begin
      $display("anagram_window_matcher_tb: FAIL");
    end
    $finish;
  end

endmodule

### anagram_window_matcher.f
design/awm_pkg.sv
design/awm_hist.sv
design/anagram_window_matcher.sv
sim/anagram_window_matcher_tb.sv
